/* rtl/k_center_radius_evaluator_defines.svh */
// Assertion macros for the RTL file that checks itself.
`ifndef K_CENTER_RADIUS_EVALUATOR_DEFINES_SVH
`define K_CENTER_RADIUS_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define KCRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define KCRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KCRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define KCRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/krad_pkg.sv */
package krad_pkg;

    // Default sizes of the block.
    localparam int MAX_CENTERS_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int CMD_W  = 2;
    localparam int SLOT_W = 4;
    localparam int NUM_W  = 5;
    localparam int DIST_W = 33;
    localparam int RAD_W  = 34;

    // Saturated radius, also the "no report yet" value of the best radius.
    localparam logic [RAD_W-1:0] RAD_MAX = '1;

    // Result payload width, padded to whole bytes.
    localparam int OUT_RAW_W  = SLOT_W + DIST_W + DIST_W + 1 + RAD_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Input commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_POINT  = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_t;

    // Result kinds.
    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_RAD_UPD,
        ST_REP_SCAN,
        ST_REP_WAIT,
        ST_REP_FIN,
        ST_EMIT
    } state_t;

    // Radius store controls.
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } rad_ctl_t;

    // One result transaction.
    typedef struct packed {
        logic              kind;
        logic [RAD_W-1:0]  best;
        logic              improved;
        logic [DIST_W-1:0] max_rad;
        logic [DIST_W-1:0] pt_dist;
        logic [SLOT_W-1:0] nearest;
    } result_t;

endpackage

/* rtl/krad_dist_pipe.sv */
module krad_dist_pipe
    import krad_pkg::*;
#(
    parameter int MAX_CENTERS = MAX_CENTERS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    localparam int IW         = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
    localparam int CNT_W      = $clog2(MAX_CENTERS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Center store write port
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_addr,
    input  logic [COORD_BITS-1:0] wr_x,
    input  logic [COORD_BITS-1:0] wr_y,
    // Scan request
    input  logic                  start,
    input  logic [CNT_W-1:0]      n_active,
    input  logic [COORD_BITS-1:0] pt_x,
    input  logic [COORD_BITS-1:0] pt_y,
    // Scan result
    output logic                  done,
    output logic [IW-1:0]         best_idx,
    output logic [RAD_W-1:0]      best_dist
);

    localparam int CB    = COORD_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > RAD_W) ? SUM_W : RAD_W;

    // Center store: x in the low half, y in the high half.
    logic [2*CB-1:0] center_mem [MAX_CENTERS];

    logic             busy_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CB-1:0]    px_reg;
    logic [CB-1:0]    py_reg;
    logic             issue;
    logic             issue_last;

    logic [2*CB-1:0]  rd_data_reg;
    logic             v1_reg, v2_reg, v3_reg;
    logic             l1_reg, l2_reg, l3_reg;
    logic [IW-1:0]    i1_reg, i2_reg, i3_reg;
    logic [CB-1:0]    dx_reg, dy_reg;
    logic [CB-1:0]    dx_next, dy_next;
    logic [SQ_W-1:0]  sx_reg, sy_reg;
    logic [RAD_W-1:0] sat_dist;

    logic             done_reg;
    logic [IW-1:0]    best_i_reg;
    logic [RAD_W-1:0] best_d_reg;

    assign issue      = busy_reg;
    assign issue_last = busy_reg && ((rd_ptr_reg + CNT_W'(1)) == n_reg);

    // Center store write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            center_mem[wr_addr] <= {wr_y, wr_x};
        end
        if (issue)
        begin
            rd_data_reg <= center_mem[rd_ptr_reg[IW-1:0]];
        end
    end

    // Read issue: one center per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            rd_ptr_reg <= '0;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            rd_ptr_reg <= '0;
        end
        else if (issue)
        begin
            rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            if (issue_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Point and count are held for the whole scan.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg  <= n_active;
            px_reg <= pt_x;
            py_reg <= pt_y;
        end
    end

    // Stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg && l3_reg;
        end
    end

    // Absolute coordinate differences.
    always_comb
    begin
        logic [CB:0] dfx;
        logic [CB:0] dfy;
        logic [CB:0] ax;
        logic [CB:0] ay;
        dfx = {rd_data_reg[CB-1], rd_data_reg[CB-1:0]} - {px_reg[CB-1], px_reg};
        dfy = {rd_data_reg[2*CB-1], rd_data_reg[2*CB-1:CB]} - {py_reg[CB-1], py_reg};
        ax  = dfx[CB] ? (~dfx + 1'b1) : dfx;
        ay  = dfy[CB] ? (~dfy + 1'b1) : dfy;
        dx_next = ax[CB-1:0];
        dy_next = ay[CB-1:0];
    end

    // Sum of squares with saturation.
    always_comb
    begin
        logic [SUM_W-1:0] sum;
        logic [CMP_W-1:0] ext;
        sum      = SUM_W'(sx_reg) + SUM_W'(sy_reg);
        ext      = CMP_W'(sum);
        sat_dist = (ext >= CMP_W'(RAD_MAX)) ? RAD_MAX : ext[RAD_W-1:0];
    end

    // Pipeline payload: difference, square, then running minimum.
    always_ff @(posedge clk)
    begin
        i1_reg <= rd_ptr_reg[IW-1:0];
        l1_reg <= issue_last;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        i2_reg <= i1_reg;
        l2_reg <= l1_reg;
        sx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        i3_reg <= i2_reg;
        l3_reg <= l2_reg;
        // Strict less-than keeps the lowest index on ties.
        if (v3_reg && ((i3_reg == '0) || (sat_dist < best_d_reg)))
        begin
            best_d_reg <= sat_dist;
            best_i_reg <= i3_reg;
        end
    end

    assign done      = done_reg;
    assign best_idx  = best_i_reg;
    assign best_dist = best_d_reg;

endmodule

/* rtl/krad_radius_store.sv */
module krad_radius_store
    import krad_pkg::*;
#(
    parameter int MAX_CENTERS = MAX_CENTERS_DEF,
    localparam int IW         = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  rad_ctl_t         ctl,
    input  logic [IW-1:0]    rd_addr,
    input  logic [IW-1:0]    wr_addr,
    input  logic [RAD_W-1:0] wr_data,
    output logic [RAD_W-1:0] rd_data
);

    // Radius memory with one valid bit per entry; an invalid entry reads as zero.
    logic [RAD_W-1:0]       rad_mem [MAX_CENTERS];
    logic [MAX_CENTERS-1:0] valid_reg;
    logic [RAD_W-1:0]       rd_q_reg;
    logic                   hit_reg;

    // Memory array write and registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            rad_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_q_reg <= rad_mem[rd_addr];
        end
    end

    // Valid bits: cleared at reset and by a report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? rd_q_reg : '0;

endmodule

/* rtl/k_center_radius_evaluator.sv */
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: cmd; tdata: slot, x, y
// m_*       out        m_tvalid/m_tready  tuser: result_kind; tdata: result fields
// cfg_*     in         cfg_wr_en          cfg_wr_data: num_centers
//
// A center load is written from the idle state. A point is scanned over n, the active
// center count: the center memory is read once per cycle into a four-stage distance
// pipeline, then the radius entry is read and raised to the distance if smaller. A
// report reads one radius memory entry per cycle. Reset clears all radii (valid bits),
// sets the best radius to all ones and the count to one. A new transaction is taken
// while a result waits in the output register; a stalled output holds the next back.
`include "k_center_radius_evaluator_defines.svh"

module k_center_radius_evaluator
    import krad_pkg::*;
#(
    parameter int MAX_CENTERS = MAX_CENTERS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    localparam int IN_DATA_W  = ((SLOT_W + 2 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [NUM_W-1:0]      cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // center_slot, coord_x, coord_y
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // nearest_cluster, point_dist_sq, max_radius_sq, improved, best_radius_sq
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_kind
    output logic [0:0]            m_tuser
);

    localparam int IW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W = $clog2(MAX_CENTERS + 1);
    localparam int CB    = COORD_BITS;

    state_t            state_reg, state_next;
    logic [NUM_W-1:0]  num_centers_reg;
    logic [CNT_W-1:0]  n_active;
    logic [RAD_W-1:0]  best_radius_reg;
    logic [RAD_W-1:0]  mx_reg;
    logic              acc_v_reg;
    logic [CNT_W-1:0]  rep_ptr_reg;
    logic              rep_last;
    result_t           res_reg;
    result_t           out_reg;
    logic              m_tvalid_reg;

    logic              s_acc;
    cmd_t              cmd;
    logic [SLOT_W-1:0] in_slot;
    logic [CB-1:0]     in_x;
    logic [CB-1:0]     in_y;
    logic              slot_ok;

    logic              ctr_wr;
    logic              dist_start;
    logic              dist_done;
    logic [IW-1:0]     dist_idx;
    logic [RAD_W-1:0]  dist_val;

    rad_ctl_t          rad_ctl;
    logic [IW-1:0]     rad_rd_addr;
    logic [RAD_W-1:0]  rad_rd_data;
    logic              rad_raise;
    logic              improved;
    logic              emit_ok;

    // Input field unpacking.
    assign cmd     = cmd_t'(s_tuser);
    assign in_slot = s_tdata[SLOT_W-1:0];
    assign in_x    = s_tdata[SLOT_W +: CB];
    assign in_y    = s_tdata[SLOT_W + CB +: CB];
    assign slot_ok = (int'(in_slot) < MAX_CENTERS);
    assign s_acc   = s_tvalid && s_tready;

    // Active center count, clamped to the valid range.
    always_comb
    begin
        if (num_centers_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (int'(num_centers_reg) > MAX_CENTERS)
        begin
            n_active = CNT_W'(MAX_CENTERS);
        end
        else
        begin
            n_active = CNT_W'(num_centers_reg);
        end
    end

    assign rep_last  = (rep_ptr_reg + CNT_W'(1)) == n_active;
    assign rad_raise = rad_rd_data < dist_val;
    assign improved  = mx_reg < best_radius_reg;
    assign emit_ok   = !m_tvalid_reg || m_tready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (cmd)
                        CMD_POINT:  state_next = ST_DIST;
                        CMD_REPORT: state_next = ST_REP_SCAN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIST:
            begin
                if (dist_done)
                begin
                    state_next = ST_RAD_UPD;
                end
            end
            ST_RAD_UPD:  state_next = ST_EMIT;
            ST_REP_SCAN:
            begin
                if (rep_last)
                begin
                    state_next = ST_REP_WAIT;
                end
            end
            ST_REP_WAIT: state_next = ST_REP_FIN;
            ST_REP_FIN:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready    = 1'b0;
        ctr_wr      = 1'b0;
        dist_start  = 1'b0;
        rad_ctl     = '0;
        rad_rd_addr = dist_idx;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctr_wr     = s_tvalid && (cmd == CMD_LOAD) && slot_ok;
                dist_start = s_tvalid && (cmd == CMD_POINT);
            end
            ST_DIST:
            begin
                rad_ctl.rd = dist_done;
            end
            ST_RAD_UPD:
            begin
                rad_ctl.wr = rad_raise;
            end
            ST_REP_SCAN:
            begin
                rad_ctl.rd  = 1'b1;
                rad_rd_addr = rep_ptr_reg[IW-1:0];
            end
            ST_REP_FIN:
            begin
                rad_ctl.clr = 1'b1;
            end
            default:
            begin
                rad_ctl = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            num_centers_reg <= NUM_W'(1);
            best_radius_reg <= RAD_MAX;
            acc_v_reg       <= 1'b0;
            rep_ptr_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_v_reg <= (state_reg == ST_REP_SCAN);
            if (cfg_wr_en)
            begin
                num_centers_reg <= cfg_wr_data;
            end
            if (state_reg == ST_IDLE)
            begin
                rep_ptr_reg <= '0;
            end
            else if (state_reg == ST_REP_SCAN)
            begin
                rep_ptr_reg <= rep_ptr_reg + CNT_W'(1);
            end
            if ((state_reg == ST_REP_FIN) && improved)
            begin
                best_radius_reg <= mx_reg;
            end
            if ((state_reg == ST_EMIT) && emit_ok)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Report maximum and pending result.
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            mx_reg <= '0;
        end
        else if (acc_v_reg && (rad_rd_data > mx_reg))
        begin
            mx_reg <= rad_rd_data;
        end
        if (state_reg == ST_RAD_UPD)
        begin
            res_reg <= '{kind: KIND_POINT, best: '0, improved: 1'b0, max_rad: '0,
                         pt_dist: dist_val[DIST_W-1:0], nearest: SLOT_W'(dist_idx)};
        end
        else if (state_reg == ST_REP_FIN)
        begin
            res_reg <= '{kind: KIND_REPORT, best: (improved ? mx_reg : best_radius_reg),
                         improved: improved, max_rad: mx_reg[DIST_W-1:0],
                         pt_dist: '0, nearest: '0};
        end
        if ((state_reg == ST_EMIT) && emit_ok)
        begin
            out_reg <= res_reg;
        end
    end

    // Output packing.
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = OUT_DATA_W'({out_reg.best, out_reg.improved, out_reg.max_rad,
                                   out_reg.pt_dist, out_reg.nearest});

    krad_dist_pipe #(
        .MAX_CENTERS (MAX_CENTERS),
        .COORD_BITS  (COORD_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (ctr_wr),
        .wr_addr   (IW'(in_slot)),
        .wr_x      (in_x),
        .wr_y      (in_y),
        .start     (dist_start),
        .n_active  (n_active),
        .pt_x      (in_x),
        .pt_y      (in_y),
        .done      (dist_done),
        .best_idx  (dist_idx),
        .best_dist (dist_val)
    );

    krad_radius_store #(
        .MAX_CENTERS (MAX_CENTERS)
    ) u_rad (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (rad_ctl),
        .rd_addr (rad_rd_addr),
        .wr_addr (dist_idx),
        .wr_data (dist_val),
        .rd_data (rad_rd_data)
    );

    // Checks.
    `KCRE_ASSERT_IMP(a_done_in_dist, clk, rst_n, dist_done, state_reg == ST_DIST,
        "scan finished outside point state")
    `KCRE_ASSERT_NXT(a_best_mono, clk, rst_n, 1'b1,
        best_radius_reg <= $past(best_radius_reg), "best radius grew")
    `KCRE_ASSERT_IMP(a_rose_emit, clk, rst_n, $rose(m_tvalid),
        $past(state_reg) == ST_EMIT, "result raised outside emit")
    `KCRE_ASSERT_IMP(a_imp_best, clk, rst_n, m_tvalid && out_reg.improved,
        out_reg.best[DIST_W-1:0] == out_reg.max_rad, "improved report with mismatched best")

endmodule
